// ===== sv/jstr_pkg.sv =====
// Package for the joystick servo teach-and-repeat block.
// Holds sizes, register indexes and the transaction payload types; no dependencies.
package jstr_pkg;

    localparam int FRAME_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int COUNT_W     = $clog2(FRAME_DEPTH + 1);
    localparam int SAMPLE_W    = 12;
    localparam int ANGLE_W     = 8;
    localparam int DB_W        = 10;
    localparam int NUM_W       = SAMPLE_W + 7;
    localparam int CNT_W       = $clog2(NUM_W + 1);

    localparam logic [2:0] REG_CENTER_0   = 3'd0;
    localparam logic [2:0] REG_CENTER_1   = 3'd1;
    localparam logic [2:0] REG_CENTER_2   = 3'd2;
    localparam logic [2:0] REG_CENTER_3   = 3'd3;
    localparam logic [2:0] REG_FULL_SCALE = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd5;

    localparam logic [ANGLE_W-1:0] ANGLE_MID = 8'd90;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic                record_press;
        logic                play_press;
    } tick_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle_0;
        logic [ANGLE_W-1:0] servo_angle_1;
        logic [ANGLE_W-1:0] servo_angle_2;
        logic [ANGLE_W-1:0] servo_angle_3;
        logic               is_recording;
        logic               is_playing;
        logic [COUNT_W-1:0] frame_number;
        logic               playback_done;
        logic               nothing_recorded;
        logic               store_full;
    } servo_t;

endpackage

// ===== sv/jstr_lane.sv =====
// One axis lane: maps a sample to a servo angle with a bit-serial restoring divider.
// Depends on jstr_pkg.
module jstr_lane
    import jstr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] center,
    input  logic [SAMPLE_W-1:0] full_scale,
    input  logic [DB_W-1:0]     dead_band,
    output logic                busy,
    output logic [ANGLE_W-1:0]  angle
);

    logic [NUM_W-1:0]    num_reg, num_next;
    logic [SAMPLE_W-1:0] den_reg, den_next;
    logic [SAMPLE_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                below_reg, below_next;
    logic                force_reg, force_next;
    logic                busy_reg, busy_next;

    logic                below;
    logic [SAMPLE_W-1:0] diff;
    logic [NUM_W-1:0]    diff_w;
    logic [SAMPLE_W:0]   lo_edge;
    logic [SAMPLE_W:0]   hi_edge;
    logic                dead;
    logic [SAMPLE_W:0]   rem_sh;
    logic [NUM_W:0]      upper_sum;

    always_comb
    begin
        below   = sample < center;
        diff    = below ? sample : sample - center;
        diff_w  = {{(NUM_W-SAMPLE_W){1'b0}}, diff};
        lo_edge = {1'b0, sample} + {{(SAMPLE_W+1-DB_W){1'b0}}, dead_band};
        hi_edge = {1'b0, center} + {{(SAMPLE_W+1-DB_W){1'b0}}, dead_band};
        dead    = (lo_edge > {1'b0, center}) && ({1'b0, sample} < hi_edge);
        rem_sh  = {rem_reg[SAMPLE_W-1:0], num_reg[NUM_W-1]};

        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        below_next = below_reg;
        force_next = force_reg;
        busy_next  = busy_reg;

        if (start)
        begin
            num_next   = (diff_w << 6) + (diff_w << 4) + (diff_w << 3) + (diff_w << 1);
            den_next   = below ? center : full_scale - center;
            rem_next   = '0;
            quo_next   = '0;
            cnt_next   = CNT_W'(NUM_W);
            below_next = below;
            force_next = dead || (!below && (full_scale <= center));
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        below_reg <= below_next;
        force_reg <= force_next;
    end

    always_comb
    begin
        upper_sum = {1'b0, quo_reg} + (NUM_W+1)'(ANGLE_MID);
        if (force_reg)
            angle = ANGLE_MID;
        else if (below_reg)
            angle = quo_reg[ANGLE_W-1:0];
        else if (upper_sum > (NUM_W+1)'(255))
            angle = '1;
        else
            angle = upper_sum[ANGLE_W-1:0];
    end

    assign busy = busy_reg;

endmodule

// ===== sv/jstr_store.sv =====
// Frame store: one write port, one registered read port.
// Depends on jstr_pkg.
module jstr_store
    import jstr_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [4*ANGLE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [4*ANGLE_W-1:0] rdata
);

    logic [4*ANGLE_W-1:0] mem [FRAME_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/joystick_servo_teach_repeat.sv =====
// Top level of the joystick servo teach-and-repeat block.
// Depends on jstr_pkg, jstr_lane and jstr_store.
//
// Each tick transaction yields one servo transaction. Four axis lanes each run a
// one-bit-per-cycle divider of 19 steps. A new tick is taken only once the result
// of the previous one is registered, and that result is held back while the
// output is stalled; a waiting result holds while the next tick is already being
// worked on. Recorded frames go to a 1024 x 32 memory with a registered read
// port. Configuration writes are always ready and take effect at once.
module joystick_servo_teach_repeat
    import jstr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_stall,
    input  tick_t               tick,
    output logic                servo_valid,
    input  logic                servo_stall,
    output servo_t              servo,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [SAMPLE_W-1:0] center_reg [4];
    logic [SAMPLE_W-1:0] fs_reg;
    logic [DB_W-1:0]     db_reg;

    logic [1:0]         state_reg, state_next;
    logic               rec_reg, rec_next;
    logic               play_reg, play_next;
    logic [COUNT_W-1:0] rf_reg, rf_next;
    logic [COUNT_W-1:0] sf_reg, sf_next;
    logic [COUNT_W-1:0] ri_reg, ri_next;
    logic               none_reg, none_next;
    logic               out_valid_reg, out_valid_next;
    servo_t             out_reg, out_next;

    logic [SAMPLE_W-1:0] samples [4];
    logic [ANGLE_W-1:0]  angles [4];
    logic [3:0]          busy;
    logic                accept;
    logic                finish;
    logic                we;
    logic [4*ANGLE_W-1:0] rdata;
    logic [COUNT_W-1:0]  ri_inc;

    assign samples[0] = tick.sample_0;
    assign samples[1] = tick.sample_1;
    assign samples[2] = tick.sample_2;
    assign samples[3] = tick.sample_3;

    assign tick_stall = (state_reg != ST_IDLE);
    assign accept     = tick_valid && !tick_stall;
    assign cfg_ready  = 1'b1;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            jstr_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .start      (accept),
                .sample     (samples[g]),
                .center     (center_reg[g]),
                .full_scale (fs_reg),
                .dead_band  (db_reg),
                .busy       (busy[g]),
                .angle      (angles[g])
            );
        end
    endgenerate

    jstr_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (rf_reg[ADDR_W-1:0]),
        .wdata ({angles[3], angles[2], angles[1], angles[0]}),
        .raddr (ri_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= 12'd1980;
            center_reg[1] <= 12'd2007;
            center_reg[2] <= 12'd1967;
            center_reg[3] <= 12'd2000;
            fs_reg        <= 12'd4029;
            db_reg        <= 10'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CENTER_0:   center_reg[0] <= cfg_data;
                REG_CENTER_1:   center_reg[1] <= cfg_data;
                REG_CENTER_2:   center_reg[2] <= cfg_data;
                REG_CENTER_3:   center_reg[3] <= cfg_data;
                REG_FULL_SCALE: fs_reg        <= cfg_data;
                REG_DEAD_BAND:  db_reg        <= cfg_data[DB_W-1:0];
                default:        ;
            endcase
        end
    end

    assign finish = (state_reg == ST_RUN) && (busy == 4'b0)
                    && (!out_valid_reg || !servo_stall);
    assign ri_inc = ri_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        play_next      = play_reg;
        rf_next        = rf_reg;
        sf_next        = sf_reg;
        ri_next        = ri_reg;
        none_next      = none_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        we             = 1'b0;

        if (out_valid_reg && !servo_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    none_next = 1'b0;
                    if (tick.record_press)
                    begin
                        rec_next = !rec_reg;
                        if (!rec_reg)
                        begin
                            play_next = 1'b0;
                            rf_next   = '0;
                        end
                        else
                            sf_next = rf_reg;
                    end
                    if (tick.play_press)
                    begin
                        rf_next = sf_next;
                        if (sf_next != '0)
                        begin
                            rec_next  = 1'b0;
                            play_next = 1'b1;
                            ri_next   = '0;
                        end
                        else
                        begin
                            play_next = 1'b0;
                            none_next = 1'b1;
                        end
                    end
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (finish)
                begin
                    out_next.servo_angle_0    = angles[0];
                    out_next.servo_angle_1    = angles[1];
                    out_next.servo_angle_2    = angles[2];
                    out_next.servo_angle_3    = angles[3];
                    out_next.is_playing       = 1'b0;
                    out_next.playback_done    = 1'b0;
                    out_next.nothing_recorded = none_reg;
                    out_next.store_full       = 1'b0;
                    out_next.frame_number     = rf_reg;
                    if (rec_reg && !play_reg)
                    begin
                        if (rf_reg < COUNT_W'(FRAME_DEPTH))
                        begin
                            we      = 1'b1;
                            rf_next = rf_reg + 1'b1;
                            out_next.frame_number = rf_reg + 1'b1;
                        end
                        else
                            out_next.store_full = 1'b1;
                    end
                    if (play_reg)
                    begin
                        out_next.servo_angle_0 = rdata[ANGLE_W-1:0];
                        out_next.servo_angle_1 = rdata[2*ANGLE_W-1:ANGLE_W];
                        out_next.servo_angle_2 = rdata[3*ANGLE_W-1:2*ANGLE_W];
                        out_next.servo_angle_3 = rdata[4*ANGLE_W-1:3*ANGLE_W];
                        out_next.is_playing    = 1'b1;
                        out_next.frame_number  = ri_inc;
                        ri_next                = ri_inc;
                        if (ri_inc >= sf_reg)
                        begin
                            play_next              = 1'b0;
                            ri_next                = '0;
                            out_next.playback_done = 1'b1;
                        end
                    end
                    out_next.is_recording = rec_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rec_reg       <= 1'b0;
            play_reg      <= 1'b0;
            rf_reg        <= '0;
            sf_reg        <= '0;
            ri_reg        <= '0;
            none_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rec_reg       <= rec_next;
            play_reg      <= play_next;
            rf_reg        <= rf_next;
            sf_reg        <= sf_next;
            ri_reg        <= ri_next;
            none_reg      <= none_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign servo_valid = out_valid_reg;
    assign servo       = out_reg;

endmodule

// ===== sv/jstr_checker.sv =====
// Port-level checker for the teach-and-repeat top level, with its bind.
// Depends on jstr_pkg and joystick_servo_teach_repeat.
module jstr_checker
    import jstr_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   servo_valid,
    input logic   servo_stall,
    input servo_t servo
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        servo_valid && servo_stall |=> servo_valid && $stable(servo))
        else $error("stalled servo transaction changed");

    a_done_play: assert property (@(posedge clk) disable iff (!rst_n)
        servo_valid && servo.playback_done |-> servo.is_playing)
        else $error("playback_done on a live frame");

    a_play_rec: assert property (@(posedge clk) disable iff (!rst_n)
        servo_valid && servo.is_playing |-> !servo.is_recording && !servo.store_full)
        else $error("replayed frame while recording");

    a_full_rec: assert property (@(posedge clk) disable iff (!rst_n)
        servo_valid && servo.store_full |->
            servo.is_recording && servo.frame_number == COUNT_W'(FRAME_DEPTH))
        else $error("store_full without a full recording");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        servo_valid && servo.nothing_recorded |-> !servo.is_playing)
        else $error("replay with nothing recorded");

endmodule

bind joystick_servo_teach_repeat jstr_checker u_jstr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .servo_valid (servo_valid),
    .servo_stall (servo_stall),
    .servo       (servo)
);

// ===== verif/tb.sv =====
// Testbench for joystick_servo_teach_repeat: directed table, then random ticks,
// each servo transaction checked against a typed expectation or a behavioral predictor.
// Depends on jstr_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
    import jstr_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tick_valid = 1'b0;
    logic                tick_stall;
    tick_t               tick = '0;
    logic                servo_valid;
    logic                servo_stall = 1'b0;
    servo_t              servo;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [SAMPLE_W-1:0] cfg_data = '0;

    joystick_servo_teach_repeat dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    int unsigned ctr [4];
    int unsigned fscale;
    int unsigned dband;
    bit          rec_on;
    bit          play_on;
    int unsigned rec_cnt;
    int unsigned saved_cnt;
    int unsigned play_idx;
    logic [31:0] frames [FRAME_DEPTH];

    servo_t      servo_expected [$];
    int          failures = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;

    function automatic logic [7:0] map_axis(int unsigned s, int unsigned c);
        int unsigned a;
        if (s < c)
            a = (s * 90) / c;
        else if (fscale > c)
        begin
            a = 90 + ((s - c) * 90) / (fscale - c);
            if (a > 255)
                a = 255;
        end
        else
            a = 90;
        if (int'(s) > int'(c) - int'(dband) && int'(s) < int'(c) + int'(dband))
            a = 90;
        return a[7:0];
    endfunction

    function automatic servo_t predict_servo(tick_t t);
        servo_t      r;
        logic [7:0]  ang [4];
        logic [31:0] w;
        int unsigned fno;
        r = '0;
        if (t.record_press)
        begin
            rec_on = !rec_on;
            if (rec_on)
            begin
                play_on = 1'b0;
                rec_cnt = 0;
            end
            else
                saved_cnt = rec_cnt;
        end
        if (t.play_press)
        begin
            rec_cnt = saved_cnt;
            if (saved_cnt > 0)
            begin
                rec_on = 1'b0;
                play_on = 1'b1;
                play_idx = 0;
            end
            else
            begin
                play_on = 1'b0;
                r.nothing_recorded = 1'b1;
            end
        end
        ang[0] = map_axis(t.sample_0, ctr[0]);
        ang[1] = map_axis(t.sample_1, ctr[1]);
        ang[2] = map_axis(t.sample_2, ctr[2]);
        ang[3] = map_axis(t.sample_3, ctr[3]);
        if (rec_on && !play_on)
        begin
            if (rec_cnt < FRAME_DEPTH)
            begin
                frames[rec_cnt] = {ang[3], ang[2], ang[1], ang[0]};
                rec_cnt++;
            end
            else
                r.store_full = 1'b1;
        end
        fno = rec_cnt;
        if (play_on)
        begin
            w = frames[play_idx];
            ang[0] = w[7:0];
            ang[1] = w[15:8];
            ang[2] = w[23:16];
            ang[3] = w[31:24];
            play_idx++;
            fno = play_idx;
            r.is_playing = 1'b1;
            if (play_idx >= saved_cnt)
            begin
                play_on = 1'b0;
                play_idx = 0;
                r.playback_done = 1'b1;
            end
        end
        r.servo_angle_0 = ang[0];
        r.servo_angle_1 = ang[1];
        r.servo_angle_2 = ang[2];
        r.servo_angle_3 = ang[3];
        r.is_recording = rec_on;
        r.frame_number = fno[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: check and stall
    always @(posedge clk)
    begin
        servo_t e;
        if (rst_n && servo_valid && !servo_stall)
        begin
            if (servo_expected.size() == 0)
            begin
                $error("unexpected servo transaction");
                failures++;
            end
            else
            begin
                e = servo_expected.pop_front();
                if (servo.servo_angle_0 !== e.servo_angle_0)
                begin
                    $error("servo_angle_0 exp %0d got %0d", e.servo_angle_0,
                           servo.servo_angle_0);
                    failures++;
                end
                if (servo.servo_angle_1 !== e.servo_angle_1)
                begin
                    $error("servo_angle_1 exp %0d got %0d", e.servo_angle_1,
                           servo.servo_angle_1);
                    failures++;
                end
                if (servo.servo_angle_2 !== e.servo_angle_2)
                begin
                    $error("servo_angle_2 exp %0d got %0d", e.servo_angle_2,
                           servo.servo_angle_2);
                    failures++;
                end
                if (servo.servo_angle_3 !== e.servo_angle_3)
                begin
                    $error("servo_angle_3 exp %0d got %0d", e.servo_angle_3,
                           servo.servo_angle_3);
                    failures++;
                end
                if (servo.is_recording !== e.is_recording)
                begin
                    $error("is_recording exp %0d got %0d", e.is_recording,
                           servo.is_recording);
                    failures++;
                end
                if (servo.is_playing !== e.is_playing)
                begin
                    $error("is_playing exp %0d got %0d", e.is_playing, servo.is_playing);
                    failures++;
                end
                if (servo.frame_number !== e.frame_number)
                begin
                    $error("frame_number exp %0d got %0d", e.frame_number,
                           servo.frame_number);
                    failures++;
                end
                if (servo.playback_done !== e.playback_done)
                begin
                    $error("playback_done exp %0d got %0d", e.playback_done,
                           servo.playback_done);
                    failures++;
                end
                if (servo.nothing_recorded !== e.nothing_recorded)
                begin
                    $error("nothing_recorded exp %0d got %0d", e.nothing_recorded,
                           servo.nothing_recorded);
                    failures++;
                end
                if (servo.store_full !== e.store_full)
                begin
                    $error("store_full exp %0d got %0d", e.store_full, servo.store_full);
                    failures++;
                end
            end
        end
        if (quiet)
            servo_stall <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            servo_stall <= 1'b1;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            rx_gap <= $urandom_range(1, 19) - 1;
            servo_stall <= 1'b1;
        end
        else
            servo_stall <= 1'b0;
    end

    task automatic send_tick(tick_t t, bit typed, servo_t want);
        servo_t p;
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick <= t;
        tick_valid <= 1'b1;
        do
            @(posedge clk);
        while (tick_stall);
        p = predict_servo(t);
        if (typed)
            servo_expected.push_back(want);
        else
            servo_expected.push_back(p);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_CENTER_3)
            ctr[idx[1:0]] = val;
        else if (idx == REG_FULL_SCALE)
            fscale = val;
        else if (idx == REG_DEAD_BAND)
            dband = val[9:0];
    endtask

    task automatic drain;
        tick_valid <= 1'b0;
        while (servo_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic tick_t tk(int a, int b, int c, int d, bit r, bit p);
        tick_t t;
        t.sample_0 = 12'(a);
        t.sample_1 = 12'(b);
        t.sample_2 = 12'(c);
        t.sample_3 = 12'(d);
        t.record_press = r;
        t.play_press = p;
        return t;
    endfunction

    function automatic servo_t sv(int a, int b, int c, int d, bit rec, int fno, bit none);
        servo_t s;
        s = '0;
        s.servo_angle_0 = 8'(a);
        s.servo_angle_1 = 8'(b);
        s.servo_angle_2 = 8'(c);
        s.servo_angle_3 = 8'(d);
        s.is_recording = rec;
        s.frame_number = COUNT_W'(fno);
        s.nothing_recorded = none;
        return s;
    endfunction

    function automatic tick_t rand_tick(int press_odds);
        tick_t t;
        t.sample_0 = 12'($urandom_range(0, 4095));
        t.sample_1 = 12'($urandom_range(0, 4095));
        t.sample_2 = 12'($urandom_range(0, 4095));
        t.sample_3 = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0)
            t.sample_0 = 12'(ctr[0] + $urandom_range(0, 120) - 60);
        t.record_press = ($urandom_range(0, press_odds) == 0);
        t.play_press = ($urandom_range(0, press_odds) == 0);
        return t;
    endfunction

    typedef struct {
        tick_t  t;
        bit     typed;
        servo_t want;
    } row_t;

    row_t        rows [$];
    int unsigned n;
    int unsigned phase;
    logic [11:0] c0;

    initial
    begin
        ctr[0] = 1980;
        ctr[1] = 2007;
        ctr[2] = 1967;
        ctr[3] = 2000;
        fscale = 4029;
        dband = 50;
        rec_on = 0;
        play_on = 0;
        rec_cnt = 0;
        saved_cnt = 0;
        play_idx = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1, sv(0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{tk(1980, 2007, 1967, 2000, 0, 0), 1, sv(90, 90, 90, 90, 0, 0, 0)});
        rows.push_back('{tk(4095, 4095, 4095, 4095, 0, 0), 0, '0});
        rows.push_back('{tk(4029, 4029, 4029, 4029, 0, 0), 1,
                         sv(180, 180, 180, 180, 0, 0, 0)});
        rows.push_back('{tk(1930, 1931, 2029, 2030, 0, 0), 0, '0});
        rows.push_back('{tk(0, 0, 0, 0, 0, 1), 1, sv(0, 0, 0, 0, 0, 0, 1)});
        rows.push_back('{tk(100, 3000, 500, 3900, 1, 0), 0, '0});
        rows.push_back('{tk(2500, 200, 4000, 1000, 0, 0), 0, '0});
        rows.push_back('{tk(0, 4095, 1, 4094, 0, 1), 0, '0});
        rows.push_back('{tk(0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{tk(0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{tk(700, 800, 900, 1000, 1, 0), 0, '0});
        rows.push_back('{tk(700, 800, 900, 1000, 0, 1), 0, '0});
        rows.push_back('{tk(300, 3300, 30, 3030, 1, 1), 0, '0});
        rows.push_back('{tk(300, 3300, 30, 3030, 1, 0), 0, '0});
        rows.push_back('{tk(10, 20, 30, 40, 1, 0), 0, '0});
        rows.push_back('{tk(4095, 0, 4095, 0, 1, 0), 0, '0});
        rows.push_back('{tk(0, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{tk(0, 0, 0, 0, 0, 0), 0, '0});
        foreach (rows[i])
            send_tick(rows[i].t, rows[i].typed, rows[i].want);
        drain();

        // fill the store to its end, then overflow
        send_tick(tk(0, 0, 0, 0, 1, 0), 0, '0);
        for (n = 0; n < FRAME_DEPTH + 3; n++)
            send_tick(rand_tick(1000000), 0, '0);
        send_tick(tk(0, 0, 0, 0, 1, 0), 0, '0);
        send_tick(tk(0, 0, 0, 0, 0, 1), 0, '0);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_CENTER_0, 12'd1);
                    write_reg(REG_CENTER_1, 12'd4094);
                    write_reg(REG_CENTER_2, 12'd2048);
                    write_reg(REG_CENTER_3, 12'd100);
                    write_reg(REG_FULL_SCALE, 12'd4095);
                    write_reg(REG_DEAD_BAND, 12'd0);
                end
                1:
                begin
                    write_reg(REG_FULL_SCALE, 12'd2);
                    write_reg(REG_DEAD_BAND, 12'd1023);
                end
                2:
                begin
                    write_reg(REG_FULL_SCALE, 12'd1000);
                    write_reg(REG_DEAD_BAND, 12'd1);
                    write_reg(REG_CENTER_3, 12'd4000);
                end
                default:
                begin
                    c0 = 12'($urandom_range(1, 4094));
                    write_reg(REG_CENTER_0, c0);
                    write_reg(REG_CENTER_1, 12'($urandom_range(1, 4094)));
                    write_reg(REG_CENTER_2, 12'($urandom_range(1, 4094)));
                    write_reg(REG_CENTER_3, 12'($urandom_range(1, 4094)));
                    write_reg(REG_FULL_SCALE, 12'($urandom_range(2, 4095)));
                    write_reg(REG_DEAD_BAND, 12'($urandom_range(0, 1023)));
                end
            endcase
            cfg_valid <= 1'b0;
            if (phase == 5)
                quiet = 1'b1;
            for (n = 0; n < 150; n++)
                send_tick(rand_tick(12), 0, '0);
            drain();
        end

        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== files.f =====
sv/jstr_pkg.sv
sv/jstr_lane.sv
sv/jstr_store.sv
sv/joystick_servo_teach_repeat.sv
sv/jstr_checker.sv
verif/tb.sv
